@@ src/ffes_pkg.sv @@
package ffes_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int EXP_TERMS_DEF = 6;

  localparam int DATA_W     = 32;
  localparam int DIR_W      = 26;
  localparam int MU_W       = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MU    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 2'd3;

  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  // what travels alongside the exp pipeline
  typedef struct packed {
    logic [2:0][DATA_W-1:0] v;
    logic [DATA_W-1:0]      i5;
    logic                   ovf;
  } side_t;

  // ln2 rounded to frac fraction bits
  function automatic logic [31:0] ln2_fix(int frac);
    logic [63:0] t;
    t = (LN2_Q64 >> (63 - frac)) + 64'd1;
    return 32'(t >> 1);
  endfunction

  // clamp to signed 32 bits and flag the clamp
  function automatic sat_t sat32(logic signed [127:0] x);
    sat_t r;
    r.ovf = 1'b1;
    if (x > 128'sd2147483647) begin
      r.val = S32_MAX;
    end else if (x < -128'sd2147483648) begin
      r.val = S32_MIN;
    end else begin
      r.val = x[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ src/ffes_in_if.sv @@
interface ffes_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] f_r0c0;
  logic signed [31:0] f_r0c1;
  logic signed [31:0] f_r0c2;
  logic signed [31:0] f_r1c0;
  logic signed [31:0] f_r1c1;
  logic signed [31:0] f_r1c2;
  logic signed [31:0] f_r2c0;
  logic signed [31:0] f_r2c1;
  logic signed [31:0] f_r2c2;

  modport source (
    output valid, f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2, f_r2c0, f_r2c1, f_r2c2,
    input  ready
  );
  modport sink (
    input  valid, f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2, f_r2c0, f_r2c1, f_r2c2,
    output ready
  );
endinterface

@@ src/ffes_out_if.sv @@
interface ffes_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] p_r0c0;
  logic signed [31:0] p_r0c1;
  logic signed [31:0] p_r0c2;
  logic signed [31:0] p_r1c0;
  logic signed [31:0] p_r1c1;
  logic signed [31:0] p_r1c2;
  logic signed [31:0] p_r2c0;
  logic signed [31:0] p_r2c1;
  logic signed [31:0] p_r2c2;
  logic signed [31:0] energy;
  logic        overflow;

  modport source (
    output valid, p_r0c0, p_r0c1, p_r0c2, p_r1c0, p_r1c1, p_r1c2, p_r2c0, p_r2c1, p_r2c2,
    output energy, overflow,
    input  ready
  );
  modport sink (
    input  valid, p_r0c0, p_r0c1, p_r0c2, p_r1c0, p_r1c1, p_r1c2, p_r2c0, p_r2c1, p_r2c2,
    input  energy, overflow,
    output ready
  );
endinterface

@@ src/fung_fiber_energy_stress_core.sv @@
// Throughput: one word per cycle unless the output buffer is full and the sink is not ready;
// every stage is a register and the exp polynomial is unrolled.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
// Reset: rst_ni is asynchronous, active low; it empties the pipeline and the output buffer
// and loads mu = 1.0 and a = (1.0, 0, 0).
module fung_fiber_energy_stress_core #(
  parameter int FRAC_BITS = ffes_pkg::FRAC_BITS_DEF,
  parameter int EXP_TERMS = ffes_pkg::EXP_TERMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffes_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ffes_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  ffes_in_if.sink                             in_i,
  ffes_out_if.source                          out_o
);

  localparam int NT       = EXP_TERMS - 1;
  localparam int IN_FLITE = 13 + 3 * NT;  // pipeline stages plus buffer entries
  localparam logic signed [32:0] ONE_W = 33'(1) << FRAC_BITS;

  typedef struct packed {
    logic [8:0][31:0] p;
    logic [31:0]      energy;
    logic             ovf;
  } out_t;

  // ---------------------------------------------------------------- config
  logic [ffes_pkg::MU_W-1:0]         mu_q;
  logic signed [ffes_pkg::DIR_W-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q     <= ffes_pkg::MU_W'(1) << FRAC_BITS;
      dir_q[0] <= ffes_pkg::DIR_W'(1) << FRAC_BITS;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffes_pkg::REG_MU:    mu_q     <= cfg_wdata_i;
        ffes_pkg::REG_DIR_X: dir_q[0] <= signed'(cfg_wdata_i[ffes_pkg::DIR_W-1:0]);
        ffes_pkg::REG_DIR_Y: dir_q[1] <= signed'(cfg_wdata_i[ffes_pkg::DIR_W-1:0]);
        ffes_pkg::REG_DIR_Z: dir_q[2] <= signed'(cfg_wdata_i[ffes_pkg::DIR_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Every stage advances together; stall only when the output buffer is full
  // and the sink does not take a word this cycle.
  logic [1:0] cnt_q;
  logic       adv;

  assign adv         = (cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready  = adv;

  // ---------------------------------------------------------------- front lanes
  logic signed [31:0] f_row [3][3];
  logic signed [31:0] v_l   [3];
  logic signed [63:0] sq_l  [3];
  logic               ovf_l [3];

  assign f_row[0][0] = in_i.f_r0c0;
  assign f_row[0][1] = in_i.f_r0c1;
  assign f_row[0][2] = in_i.f_r0c2;
  assign f_row[1][0] = in_i.f_r1c0;
  assign f_row[1][1] = in_i.f_r1c1;
  assign f_row[1][2] = in_i.f_r1c2;
  assign f_row[2][0] = in_i.f_r2c0;
  assign f_row[2][1] = in_i.f_r2c1;
  assign f_row[2][2] = in_i.f_r2c2;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    ffes_lane_dot #(
      .FRAC_BITS (FRAC_BITS)
    ) u_dot (
      .clk_i (clk_i),
      .adv_i (adv),
      .f_i   (f_row[i]),
      .a_i   (dir_q),
      .v_o   (v_l[i]),
      .sq_o  (sq_l[i]),
      .ovf_o (ovf_l[i])
    );
  end

  // three front stages of valid
  logic [2:0] vld_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= '0;
    end else if (adv) begin
      vld_f_q <= {vld_f_q[1:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------- merge: I5
  logic [65:0]      sum_sq;
  logic [65:0]      i5_full;
  logic [31:0]      i5;
  logic             i5_ovf;
  ffes_pkg::side_t  side_m_d;
  ffes_pkg::side_t  side_m_q;
  logic             vld_m_q;

  always_comb begin
    sum_sq  = 66'(sq_l[0]) + 66'(sq_l[1]) + 66'(sq_l[2]);
    i5_full = sum_sq >> FRAC_BITS;
    i5_ovf  = i5_full > 66'(ffes_pkg::S32_MAX);
    i5      = i5_ovf ? ffes_pkg::S32_MAX : i5_full[31:0];
    for (int i = 0; i < 3; i++) begin
      side_m_d.v[i] = v_l[i];
    end
    side_m_d.i5  = i5;
    side_m_d.ovf = ovf_l[0] | ovf_l[1] | ovf_l[2] | i5_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else if (adv) begin
      vld_m_q <= vld_f_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_m_q <= side_m_d;
    end
  end

  // ---------------------------------------------------------------- exp
  logic            vld_e;
  ffes_pkg::side_t side_e;
  logic [31:0]     e_val;

  ffes_exp #(
    .FRAC_BITS (FRAC_BITS),
    .EXP_TERMS (EXP_TERMS)
  ) u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (vld_m_q),
    .side_i (side_m_q),
    .vld_o  (vld_e),
    .side_o (side_e),
    .e_o    (e_val)
  );

  // ---------------------------------------------------------------- s and energy
  logic signed [32:0] em1;
  logic signed [32:0] ei5;
  logic signed [31:0] mu_s;
  logic signed [64:0] prod_s_q;
  logic signed [64:0] prod_en_q;
  ffes_pkg::side_t    side_s1_q;
  ffes_pkg::side_t    side_s2_d;
  ffes_pkg::side_t    side_s2_q;
  ffes_pkg::sat_t     ss;
  ffes_pkg::sat_t     se;
  logic signed [31:0] s_q;
  logic [31:0]        en_s2_q;
  logic [1:0]         vld_s_q;

  always_comb begin
    em1  = 33'(signed'(e_val)) - ONE_W;
    ei5  = 33'(signed'(e_val)) - 33'(signed'(side_e.i5));
    mu_s = signed'({1'b0, mu_q});
    ss   = ffes_pkg::sat32(128'(prod_s_q >>> (FRAC_BITS - 1)));
    se   = ffes_pkg::sat32(128'(prod_en_q >>> FRAC_BITS));
    side_s2_d     = side_s1_q;
    side_s2_d.ovf = side_s1_q.ovf | ss.ovf | se.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= '0;
    end else if (adv) begin
      vld_s_q <= {vld_s_q[0], vld_e};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_s_q  <= mu_s * em1;
      prod_en_q <= mu_s * ei5;
      side_s1_q <= side_e;
      s_q       <= signed'(ss.val);
      en_s2_q   <= se.val;
      side_s2_q <= side_s2_d;
    end
  end

  // ---------------------------------------------------------------- stress lanes
  logic signed [31:0] p_l   [3][3];
  logic               povf_l [3];

  for (genvar i = 0; i < 3; i++) begin : g_stress
    ffes_lane_stress #(
      .FRAC_BITS (FRAC_BITS)
    ) u_stress (
      .clk_i (clk_i),
      .adv_i (adv),
      .s_i   (s_q),
      .v_i   (signed'(side_s2_q.v[i])),
      .a_i   (dir_q),
      .p_o   (p_l[i]),
      .ovf_o (povf_l[i])
    );
  end

  // carry energy and flag alongside the stress lanes
  logic [2:0]  vld_b_q;
  logic [31:0] en_b_q  [3];
  logic [2:0]  ovf_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= '0;
    end else if (adv) begin
      vld_b_q <= {vld_b_q[1:0], vld_s_q[1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      en_b_q[0] <= en_s2_q;
      en_b_q[1] <= en_b_q[0];
      en_b_q[2] <= en_b_q[1];
      ovf_b_q   <= {ovf_b_q[1:0], side_s2_q.ovf};
    end
  end

  // ---------------------------------------------------------------- output buffer
  out_t res_d;
  out_t buf_q [2];
  logic wr_ptr_q;
  logic rd_ptr_q;
  logic push;
  logic pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        res_d.p[i*3+j] = p_l[i][j];
      end
    end
    res_d.energy = en_b_q[2];
    res_d.ovf    = ovf_b_q[2] | povf_l[0] | povf_l[1] | povf_l[2];
  end

  assign push = vld_b_q[2] && adv;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_o.valid    = cnt_q != 2'd0;
  assign out_o.p_r0c0   = buf_q[rd_ptr_q].p[0];
  assign out_o.p_r0c1   = buf_q[rd_ptr_q].p[1];
  assign out_o.p_r0c2   = buf_q[rd_ptr_q].p[2];
  assign out_o.p_r1c0   = buf_q[rd_ptr_q].p[3];
  assign out_o.p_r1c1   = buf_q[rd_ptr_q].p[4];
  assign out_o.p_r1c2   = buf_q[rd_ptr_q].p[5];
  assign out_o.p_r2c0   = buf_q[rd_ptr_q].p[6];
  assign out_o.p_r2c1   = buf_q[rd_ptr_q].p[7];
  assign out_o.p_r2c2   = buf_q[rd_ptr_q].p[8];
  assign out_o.energy   = buf_q[rd_ptr_q].energy;
  assign out_o.overflow = buf_q[rd_ptr_q].ovf;

  // ---------------------------------------------------------------- checks
  // words accepted but not yet delivered
  logic [6:0] infl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
    end else begin
      infl_q <= infl_q + 7'(in_i.valid && in_i.ready) - 7'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && cnt_q == 2'd2))
    else $error("output buffer written while full");

  a_infl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q <= 7'(IN_FLITE))
    else $error("more words in flight than pipeline and buffer hold");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> infl_q != 7'd0)
    else $error("output word with no accepted input behind it");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_b_q) && $stable(vld_m_q))
    else $error("pipeline moved during a stall");

endmodule

@@ src/ffes_lane_dot.sv @@
// One row of F: v = row . a, then v squared. Three stages.
module ffes_lane_dot #(
  parameter int FRAC_BITS = ffes_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic signed [31:0] f_i [3],
  input  logic signed [25:0] a_i [3],
  output logic signed [31:0] v_o,
  output logic signed [63:0] sq_o,
  output logic               ovf_o
);

  logic signed [57:0] prod_q [3];
  logic signed [59:0] acc;
  ffes_pkg::sat_t     vs;
  logic signed [31:0] v_q;
  logic               ovf_q;
  logic signed [31:0] v2_q;
  logic               ovf2_q;
  logic signed [63:0] sq_q;

  always_comb begin
    acc = 60'(prod_q[0]) + 60'(prod_q[1]) + 60'(prod_q[2]);
    vs  = ffes_pkg::sat32(128'(acc >>> FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= f_i[j] * a_i[j];
      end
      v_q    <= signed'(vs.val);
      ovf_q  <= vs.ovf;
      sq_q   <= v_q * v_q;
      v2_q   <= v_q;
      ovf2_q <= ovf_q;
    end
  end

  assign v_o   = v2_q;
  assign sq_o  = sq_q;
  assign ovf_o = ovf2_q;

endmodule

@@ src/ffes_lane_stress.sv @@
// One row of P: w = s * v[i], then P[i][j] = w * a[j]. Three stages.
module ffes_lane_stress #(
  parameter int FRAC_BITS = ffes_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic signed [31:0] s_i,
  input  logic signed [31:0] v_i,
  input  logic signed [25:0] a_i [3],
  output logic signed [31:0] p_o [3],
  output logic               ovf_o
);

  logic signed [63:0] wp_q;
  ffes_pkg::sat_t     ws;
  logic signed [57:0] pp_q [3];
  logic               wovf_q;
  ffes_pkg::sat_t     ps [3];
  logic signed [31:0] p_q [3];
  logic               ovf_q;

  always_comb begin
    ws = ffes_pkg::sat32(128'(wp_q >>> FRAC_BITS));
    for (int j = 0; j < 3; j++) begin
      ps[j] = ffes_pkg::sat32(128'(pp_q[j] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wp_q   <= s_i * v_i;
      wovf_q <= ws.ovf;
      for (int j = 0; j < 3; j++) begin
        pp_q[j] <= signed'(ws.val) * a_i[j];
        p_q[j]  <= signed'(ps[j].val);
      end
      ovf_q <= wovf_q | ps[0].ovf | ps[1].ovf | ps[2].ovf;
    end
  end

  assign p_o   = p_q;
  assign ovf_o = ovf_q;

endmodule

@@ src/ffes_exp.sv @@
// e = exp(I5 - 1): range reduction by ln2, Horner polynomial, scale by 2^k.
// One word per cycle while adv_i is high; adv_i low holds every stage.
module ffes_exp #(
  parameter int FRAC_BITS = ffes_pkg::FRAC_BITS_DEF,
  parameter int EXP_TERMS = ffes_pkg::EXP_TERMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  ffes_pkg::side_t     side_i,
  output logic                vld_o,
  output ffes_pkg::side_t     side_o,
  output logic [31:0]         e_o
);

  localparam int NT   = EXP_TERMS - 1;
  localparam int PW   = FRAC_BITS + 2;
  localparam int KW   = 6;
  localparam int KCAP = 34;
  localparam int QW   = 34;
  localparam int MW   = 36;
  localparam logic [31:0]   LN2   = ffes_pkg::ln2_fix(FRAC_BITS);
  localparam logic [QW-1:0] QOFS  = QW'((64'(LN2) << 1) - (64'd1 << FRAC_BITS));
  localparam logic [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;

  // range reduction
  logic [QW-1:0]        q;
  logic [KCAP-1:0]      ge;
  logic [KW-1:0]        qt;
  logic [QW-1:0]        r_full;

  always_comb begin
    q = QW'(side_i.i5) + QOFS;
    for (int m = 1; m <= KCAP; m++) begin
      ge[m-1] = MW'(q) >= MW'(m) * MW'(LN2);
    end
    qt     = KW'($countones(ge));
    r_full = q - QW'(MW'(qt) * MW'(LN2));
  end

  logic                  vld_c  [NT+1];
  ffes_pkg::side_t       side_c [NT+1];
  logic [KW-1:0]         k_c    [NT+1];
  logic [FRAC_BITS-1:0]  r_c    [NT+1];
  logic [PW-1:0]         p_c    [1:NT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c[0] <= 1'b0;
    end else if (adv_i) begin
      vld_c[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_c[0] <= side_i;
      k_c[0]    <= qt;
      r_c[0]    <= r_full[FRAC_BITS-1:0];
    end
  end

  // one polynomial term per three stages: p*r, times 1/n, correct and add one
  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int N = NT - j;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

    logic [PW-1:0]         p_src;
    logic [PW+FRAC_BITS-1:0] prod_q;
    logic                  vld_a, vld_b;
    ffes_pkg::side_t       side_a, side_b;
    logic [KW-1:0]         k_a, k_b;
    logic [FRAC_BITS-1:0]  r_a, r_b;
    logic [PW-1:0]         t;
    logic [PW-1:0]         t_q;
    logic [PW+32:0]        m_q;
    logic [PW-1:0]         qe;
    logic [PW+3:0]         rem;
    logic [PW-1:0]         qc;

    if (j == 0) begin : g_first
      assign p_src = ONE_P;
    end else begin : g_next
      assign p_src = p_c[j];
    end

    always_comb begin
      t   = PW'(prod_q >> FRAC_BITS);
      qe  = PW'(m_q >> 32);
      rem = (PW+4)'(t_q) - (PW+4)'(qe) * (PW+4)'(N);
      qc  = (rem >= (PW+4)'(N)) ? qe + PW'(1) : qe;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_a      <= 1'b0;
        vld_b      <= 1'b0;
        vld_c[j+1] <= 1'b0;
      end else if (adv_i) begin
        vld_a      <= vld_c[j];
        vld_b      <= vld_a;
        vld_c[j+1] <= vld_b;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        prod_q      <= (PW+FRAC_BITS)'(p_src) * (PW+FRAC_BITS)'(r_c[j]);
        side_a      <= side_c[j];
        k_a         <= k_c[j];
        r_a         <= r_c[j];
        m_q         <= (PW+33)'(t) * (PW+33)'(RECIP);
        t_q         <= t;
        side_b      <= side_a;
        k_b         <= k_a;
        r_b         <= r_a;
        p_c[j+1]    <= ONE_P + qc;
        side_c[j+1] <= side_b;
        k_c[j+1]    <= k_b;
        r_c[j+1]    <= r_b;
      end
    end
  end

  // scale by 2^(qt-2), saturate when too large
  logic [31:0] e_d;
  logic        eovf;
  logic [63:0] sh;

  always_comb begin
    eovf = 1'b0;
    sh   = 64'(p_c[NT]) << (k_c[NT] - KW'(2));
    if (k_c[NT] < KW'(2)) begin
      e_d = 32'(p_c[NT] >> (KW'(2) - k_c[NT]));
    end else if (k_c[NT] >= KW'(KCAP)) begin
      e_d  = ffes_pkg::S32_MAX;
      eovf = 1'b1;
    end else if (sh > 64'(ffes_pkg::S32_MAX)) begin
      e_d  = ffes_pkg::S32_MAX;
      eovf = 1'b1;
    end else begin
      e_d = sh[31:0];
    end
  end

  ffes_pkg::side_t side_d;

  always_comb begin
    side_d     = side_c[NT];
    side_d.ovf = side_c[NT].ovf | eovf;
  end

  logic            vld_q;
  ffes_pkg::side_t side_q;
  logic [31:0]     e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_c[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_d;
      e_q    <= e_d;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign e_o    = e_q;

endmodule
